// ===== rtl/plm_pkg.sv =====
package plm_pkg;

   // Payload widths
   localparam int SAMPLE_W  = 16;
   localparam int PEAK_W    = 15;
   localparam int CHANNEL_W = 3;
   localparam int LEVEL_W   = 14;
   localparam int COUNT_W   = 4;

   // Channel count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

   // Level reported for a zero peak
   localparam logic [LEVEL_W-1:0] LEVEL_SILENCE = 14'd10000;

   // 2000*log10(2) in Q.20
   localparam logic [31:0] LOG_SCALE = 32'd631305657;

   // Fraction bits of the log2 result
   localparam int LOG_FRAC_BITS = 28;

   // Request into the log unit
   typedef struct packed {
      logic              start;
      logic [PEAK_W-1:0] peak;
   } log_ctrl_type;

   // Result out of the log unit
   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] level;
   } log_status_type;

endpackage

// ===== rtl/plm_req_if.sv =====
interface plm_req_if;
   import plm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       block_end;

   modport source (output valid, output sample, output block_end, input ready);
   modport sink   (input valid, input sample, input block_end, output ready);
endinterface

// ===== rtl/plm_rsp_if.sv =====
interface plm_rsp_if;
   import plm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic [LEVEL_W-1:0]   level;
   logic                 last_level;

   modport source (output valid, output channel, output level, output last_level,
                   input ready);
   modport sink   (input valid, input channel, input level, input last_level,
                   output ready);
endinterface

// ===== rtl/peak_level_meter_log_unit.sv =====
// Peak level meter with a log readout. Interleaved signed samples stream in on
// req_chan, channel 0 first; each channel keeps its largest positive sample.
// A sample with block_end set is counted, then one result per active channel
// (channel_count, 1..8, written on csr_we/csr_wdata) goes out on rsp_chan in
// channel order, carrying the level in hundredths of dB below full scale
// (10000 for silence), with last_level on the final channel. Samples without
// block_end are taken back to back. After a block_end sample the block is not
// ready while it flushes: the log unit works out each channel with 28 squaring
// passes through its single 32x32 multiplier (a silent channel skips them), and
// each result may wait to be taken. Peaks and position then clear and samples
// flow again.
module peak_level_meter_log_unit #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   plm_req_if.sink                     req_chan,
   plm_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [plm_pkg::COUNT_W-1:0] csr_wdata
);
   import plm_pkg::*;

   localparam int PEAK_DEPTH = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
   localparam int IDX_W      = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CHANNEL_W-1:0] pos_ff, pos_in;
   logic [CHANNEL_W-1:0] flush_ff, flush_in;
   logic [PEAK_W-1:0]    peak_ff [PEAK_DEPTH];
   logic [PEAK_W-1:0]    peak_in [PEAK_DEPTH];
   logic [CHANNEL_W-1:0] chan_ff, chan_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 last_ff, last_in;

   logic [COUNT_W-1:0]   n_act;
   logic [CHANNEL_W-1:0] pos_sel;
   logic [COUNT_W-1:0]   pos_next;
   logic [CHANNEL_W-1:0] rd_idx;
   logic [PEAK_W-1:0]    peak_rd;
   logic                 take;

   log_ctrl_type   log_ctrl;
   log_status_type log_status;

   // Active channel count, clamped to 1..limit
   always_comb begin
      if (count_ff == '0) begin
         n_act = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(PEAK_DEPTH)) begin
         n_act = COUNT_W'(PEAK_DEPTH);
      end else begin
         n_act = count_ff;
      end
   end

   // Position of this sample and of the next one
   assign pos_sel  = ({1'b0, pos_ff} >= n_act) ? '0 : pos_ff;
   assign pos_next = ({1'b0, pos_sel} + 4'd1 >= n_act) ? '0 : {1'b0, pos_sel} + 4'd1;

   // Single read port on the peak registers
   assign rd_idx  = (state_ff == ST_RUN) ? pos_sel : flush_ff;
   assign peak_rd = peak_ff[rd_idx[IDX_W-1:0]];

   assign take = req_chan.valid && (state_ff == ST_RUN);

   assign log_ctrl.start = (state_ff == ST_START);
   assign log_ctrl.peak  = peak_rd;

   plm_log_unit u_log (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (log_ctrl),
      .status (log_status)
   );

   // Sequencer and peak tracking
   always_comb begin
      state_in = state_ff;
      count_in = csr_we ? csr_wdata : count_ff;
      pos_in   = pos_ff;
      flush_in = flush_ff;
      peak_in  = peak_ff;
      chan_in  = chan_ff;
      level_in = level_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_RUN: begin
            if (take) begin
               if ($signed(req_chan.sample) > $signed({1'b0, peak_rd})) begin
                  peak_in[pos_sel[IDX_W-1:0]] = req_chan.sample[PEAK_W-1:0];
               end
               if (req_chan.block_end) begin
                  pos_in   = '0;
                  flush_in = '0;
                  state_in = ST_START;
               end else begin
                  pos_in = pos_next[CHANNEL_W-1:0];
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (log_status.done) begin
               chan_in  = flush_ff;
               level_in = log_status.level;
               last_in  = ({1'b0, flush_ff} + 4'd1 == n_act);
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (last_ff) begin
                  for (int i = 0; i < PEAK_DEPTH; i++) begin
                     peak_in[i] = '0;
                  end
                  state_in = ST_RUN;
               end else begin
                  flush_in = flush_ff + 3'd1;
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         count_ff <= COUNT_RESET;
         pos_ff   <= '0;
         flush_ff <= '0;
         for (int i = 0; i < PEAK_DEPTH; i++) begin
            peak_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         flush_ff <= flush_in;
         peak_ff  <= peak_in;
      end
      chan_ff  <= chan_in;
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   // Ports
   assign req_chan.ready      = (state_ff == ST_RUN);
   assign rsp_chan.valid      = (state_ff == ST_SEND);
   assign rsp_chan.channel    = chan_ff;
   assign rsp_chan.level      = level_ff;
   assign rsp_chan.last_level = last_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input taken while a result is pending");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_level) |-> ({1'b0, rsp_chan.channel} + 4'd1 == n_act))
      else $error("last_level on a channel other than the final one");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      log_status.done |-> (state_ff == ST_WAIT))
      else $error("log result arrived outside the wait state");

   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      (take && req_chan.block_end) |=> (state_ff == ST_START && flush_ff == '0))
      else $error("block end did not start the flush at channel 0");
`endif

endmodule

// ===== rtl/plm_log_unit.sv =====
module plm_log_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  plm_pkg::log_ctrl_type   ctrl,
   output plm_pkg::log_status_type status
);
   import plm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_DIFF   = 2'd2;
   localparam logic [1:0] ST_SCALE  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [31:0]              x_ff, x_in;
   logic [3:0]               m_ff, m_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [4:0]               iter_ff, iter_in;
   logic [31:0]              d_ff, d_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic                     done_ff, done_in;

   logic [3:0]  lead;
   logic [31:0] x_init;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [32:0] sq;

   // Leading one of the peak
   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < PEAK_W; i++) begin
         if (ctrl.peak[i]) begin
            lead = 4'(i);
         end
      end
   end

   // Mantissa in Q1.31
   assign x_init = {17'b0, ctrl.peak} << (5'd31 - {1'b0, lead});

   // Shared multiplier: squaring, then the final scale
   assign mul_a = (state_ff == ST_SCALE) ? d_ff : x_ff;
   assign mul_b = (state_ff == ST_SCALE) ? LOG_SCALE : x_ff;
   assign prod  = {32'b0, mul_a} * {32'b0, mul_b};
   assign sq    = prod[63:31];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      iter_in  = iter_ff;
      d_in     = d_ff;
      level_in = level_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               if (ctrl.peak == '0) begin
                  level_in = LEVEL_SILENCE;
                  done_in  = 1'b1;
               end else begin
                  x_in     = x_init;
                  m_in     = lead;
                  frac_in  = '0;
                  iter_in  = '0;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            // One fraction bit per square
            if (sq[32]) begin
               x_in    = sq[32:1];
               frac_in = {frac_ff[LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
               x_in    = sq[31:0];
               frac_in = {frac_ff[LOG_FRAC_BITS-2:0], 1'b0};
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(LOG_FRAC_BITS - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            d_in     = {4'd15, 28'd0} - {m_ff, frac_ff};
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            level_in = prod[61:48];
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff     <= x_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      iter_ff  <= iter_in;
      d_ff     <= d_in;
      level_ff <= level_in;
   end

   assign status.done  = done_ff;
   assign status.level = level_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import plm_pkg::*;

   localparam int METER_CHANNELS = 8;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CHUNK_SAMPLES  = 22;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } audio_sample_type;

   typedef struct {
      logic [CHANNEL_W-1:0] channel;
      logic [LEVEL_W-1:0]   level;
      logic                 last_level;
   } level_report_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [COUNT_W-1:0]  csr_wdata;

   plm_req_if req_chan ();
   plm_rsp_if rsp_chan ();

   peak_level_meter_log_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   audio_sample_type pending_samples[$];
   level_report_type expected_levels[$];
   audio_sample_type current_sample = '{16'sd0, 1'b0};

   // Meter state as the block should hold it
   int                  meter_peak[METER_CHANNELS];
   int                  meter_position;
   logic [COUNT_W-1:0]  meter_count;

   int  error_count = 0;
   int  sender_gap = 0;
   int  receiver_stall = 0;
   bit  sender_quiet = 1'b0;
   bit  receiver_quiet = 1'b0;

   // Channel count as used: zero means one, above the limit saturates
   function automatic int active_channel_count();
      if (meter_count == 0) return 1;
      if (meter_count > METER_CHANNELS) return METER_CHANNELS;
      return int'(meter_count);
   endfunction

   // Attenuation below full scale in hundredths of dB, fixed-point log2
   function automatic logic [LEVEL_W-1:0] level_of_peak(input logic [PEAK_W-1:0] peak);
      logic [63:0] mant;
      logic [63:0] frac;
      logic [63:0] log2q;
      logic [63:0] scaled;
      int          msb;
      int          b;
      if (peak == '0) return LEVEL_SILENCE;
      msb = 0;
      for (b = 0; b < PEAK_W; b++)
         if (peak[b]) msb = b;
      mant = 64'(peak) << (31 - msb);
      frac = '0;
      for (b = 0; b < LOG_FRAC_BITS; b++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= (64'd1 << 32)) begin
            frac = frac | 64'd1;
            mant = mant >> 1;
         end
      end
      log2q  = (64'(msb) << LOG_FRAC_BITS) | frac;
      scaled = (((64'd15 << LOG_FRAC_BITS) - log2q) * 64'(LOG_SCALE)) >> 48;
      return scaled[LEVEL_W-1:0];
   endfunction

   // Fold one accepted sample into the peaks; a block end queues the levels
   task automatic take_sample(input audio_sample_type item);
      int n;
      int k;
      n = active_channel_count();
      if (meter_position >= n) meter_position = 0;
      if (int'(item.sample) > meter_peak[meter_position])
         meter_peak[meter_position] = int'(item.sample);
      meter_position++;
      if (meter_position >= n) meter_position = 0;
      if (item.block_end) begin
         for (k = 0; k < n; k++)
            expected_levels.push_back('{CHANNEL_W'(k),
                                       level_of_peak(PEAK_W'(meter_peak[k])),
                                       (k == n - 1)});
         for (k = 0; k < METER_CHANNELS; k++) meter_peak[k] = 0;
         meter_position = 0;
      end
   endtask

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Extremes, full-range noise, and values of every magnitude, mostly positive
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] raw;
      int                  span;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: raw = 16'h8000;
               1: raw = 16'h7fff;
               2: raw = 16'h0000;
               3: raw = 16'h0001;
               default: raw = 16'hffff;
            endcase
         end
         1, 2: raw = 16'($urandom);
         default: begin
            span = $urandom_range(0, 14);
            raw = 16'($urandom) & ((16'd1 << (span + 1)) - 16'd1);
            if ($urandom_range(0, 4) == 0) raw = -raw;
         end
      endcase
      return $signed(raw);
   endfunction

   task automatic push_sample(input int value, input logic block_end);
      pending_samples.push_back('{SAMPLE_W'(value), block_end});
   endtask

   // Whole blocks of frames with random content; some short blocks and stray flags
   task automatic queue_random_blocks(input int target);
      audio_sample_type item;
      int               n;
      int               len;
      int               made;
      int               i;
      n = active_channel_count();
      made = 0;
      while (made < target) begin
         len = $urandom_range(1, 4) * n;
         if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
         for (i = 0; i < len; i++) begin
            item.sample    = random_sample();
            item.block_end = (i == len - 1);
            if ($urandom_range(0, 19) == 0) item.block_end = ~item.block_end;
            pending_samples.push_back(item);
         end
         made += len;
      end
      // leave a frame half done now and then, ahead of a count change
      if ($urandom_range(0, 2) == 0) begin
         len = $urandom_range(1, 3);
         for (i = 0; i < len; i++) begin
            item.sample    = random_sample();
            item.block_end = 1'b0;
            pending_samples.push_back(item);
         end
      end
   endtask

   // Hold off until every sample is taken and every level has come back;
   // checked at the falling edge so the driver's updates have settled
   task automatic drain();
      while (pending_samples.size() != 0 || req_chan.valid || expected_levels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_channel_count(input logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      meter_count = value;
   endtask

   // Sample driver
   always @(posedge clock) begin : sample_driver
      audio_sample_type next_item;
      logic             next_valid;
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.sample    <= '0;
         req_chan.block_end <= 1'b0;
         sender_gap = 0;
      end else begin
         next_item  = current_sample;
         next_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            take_sample(current_sample);
            next_valid = 1'b0;
            sender_gap = pick_gap(sender_quiet);
         end
         if (!next_valid) begin
            if (sender_gap > 0) begin
               sender_gap--;
            end else if (pending_samples.size() != 0) begin
               next_item  = pending_samples.pop_front();
               next_valid = 1'b1;
            end
         end
         current_sample      = next_item;
         req_chan.valid     <= next_valid;
         req_chan.sample    <= next_item.sample;
         req_chan.block_end <= next_item.block_end;
      end
   end

   // Level monitor: check each transfer against the oldest expected level
   always @(posedge clock) begin : level_monitor
      level_report_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         receiver_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_levels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected level, expected none, actual ch %0d level %0d last %0b",
                        $time, rsp_chan.channel, rsp_chan.level, rsp_chan.last_level);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_chan.channel !== want.channel) begin
                  error_count++;
                  $display("%0t: channel mismatch, expected %0d, actual %0d",
                           $time, want.channel, rsp_chan.channel);
               end
               if (rsp_chan.level !== want.level) begin
                  error_count++;
                  $display("%0t: level mismatch on ch %0d, expected %0d, actual %0d",
                           $time, want.channel, want.level, rsp_chan.level);
               end
               if (rsp_chan.last_level !== want.last_level) begin
                  error_count++;
                  $display("%0t: last_level mismatch on ch %0d, expected %0b, actual %0b",
                           $time, want.channel, want.last_level, rsp_chan.last_level);
               end
            end
            receiver_stall = pick_gap(receiver_quiet);
         end else if (!rsp_chan.valid && $urandom_range(0, 15) == 0) begin
            receiver_stall = pick_gap(receiver_quiet);
         end
         if (receiver_stall > 0) begin
            receiver_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [COUNT_W-1:0] count_plan[12];
      int                 i;
      int                 p;
      count_plan = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd6, 4'd2, 4'd8,
                     4'd4, 4'd7, 4'd5, 4'd12};
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      meter_count        = COUNT_RESET;
      meter_position     = 0;
      for (i = 0; i < METER_CHANNELS; i++) meter_peak[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full scale and most negative, then the smallest positive peak
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b1);
      push_sample(1, 1'b0);
      push_sample(0, 1'b1);
      // partial frame: channel 1 got nothing and reads silence
      push_sample(16384, 1'b1);
      // negatives never raise a peak
      push_sample(-1, 1'b0);
      push_sample(300, 1'b0);
      push_sample(200, 1'b0);
      push_sample(-5, 1'b1);
      // stop mid-frame so the next count change has to wrap the position
      push_sample(5, 1'b0);
      push_sample(6, 1'b0);
      push_sample(7, 1'b0);
      drain();
      set_channel_count(4'd1);
      push_sample(9, 1'b1);
      drain();
      // zero count behaves as one channel
      set_channel_count(4'd0);
      push_sample(-32768, 1'b0);
      push_sample(2, 1'b1);
      drain();
      // count above the limit saturates to eight channels
      set_channel_count(4'd15);
      for (i = 0; i < METER_CHANNELS; i++)
         push_sample(32767 >> i, i == METER_CHANNELS - 1);
      drain();

      // random blocks over a sweep of channel counts
      for (p = 0; p < 12; p++) begin
         sender_quiet   = ($urandom_range(0, 4) == 0);
         receiver_quiet = ($urandom_range(0, 4) == 0);
         if (p % 4 != 3) set_channel_count(count_plan[p]);
         queue_random_blocks(CHUNK_SAMPLES);
         drain();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/plm_pkg.sv
rtl/plm_req_if.sv
rtl/plm_rsp_if.sv
rtl/plm_log_unit.sv
rtl/peak_level_meter_log_unit.sv
tb/testbench.sv
